// File: src/ship_track_dead_reckoning_macros.svh
// assertion macros for the dead reckoning track table
`ifndef SHIP_TRACK_DEAD_RECKONING_MACROS_SVH
`define SHIP_TRACK_DEAD_RECKONING_MACROS_SVH
`ifndef SYNTHESIS
`define STDR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define STDR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define STDR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define STDR_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: src/stdr_pkg.sv
// shared types, constants and tables of the dead reckoning track table
package stdr_pkg;

    localparam int MAX_TRACKS_DEF = 256;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [10:0] DIV_CONST = 11'd1000;
    localparam logic [48:0] DIV_BIAS = 49'd999;

    typedef struct packed {
        logic               req;
        logic               ok;
        logic [7:0]         idx;
        logic [31:0]        t;
        logic signed [31:0] east;
        logic signed [31:0] north;
        logic signed [15:0] speed;
        logic [15:0]        heading;
        logic signed [15:0] turn;
    } stdr_item_t;

    typedef struct packed {
        logic       valid;
        stdr_item_t item;
    } stdr_queue_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } stdr_back_ctl_t;

    typedef struct packed {
        logic signed [31:0] east;
        logic signed [31:0] north;
        logic signed [15:0] speed;
        logic [15:0]        heading;
        logic signed [15:0] turn;
        logic [31:0]        stamp;
    } stdr_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DELTA,
        ST_MROT,
        ST_HGO,
        ST_HWAIT,
        ST_CGO,
        ST_CWAIT,
        ST_MP,
        ST_PSAVE,
        ST_MEH,
        ST_MEL,
        ST_ADD,
        ST_EGO,
        ST_EWAIT,
        ST_OUT
    } stdr_state_t;

    function automatic logic [33:0] atan_val(input logic [3:0] i);
        logic [33:0] v;
        case (i)
            4'd0:    v = 34'd536870912;
            4'd1:    v = 34'd316933406;
            4'd2:    v = 34'd167458907;
            4'd3:    v = 34'd85004756;
            4'd4:    v = 34'd42667331;
            4'd5:    v = 34'd21354465;
            4'd6:    v = 34'd10679838;
            4'd7:    v = 34'd5340245;
            4'd8:    v = 34'd2670163;
            4'd9:    v = 34'd1335087;
            4'd10:   v = 34'd667544;
            4'd11:   v = 34'd333772;
            4'd12:   v = 34'd166886;
            4'd13:   v = 34'd83443;
            4'd14:   v = 34'd41722;
            4'd15:   v = 34'd20861;
            default: v = 34'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/stdr_div1000.sv
// iterative floor division of a signed value by 1000, four quotient bits a cycle
module stdr_div1000 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] num,
    output logic               busy,
    output logic               done,
    output logic signed [47:0] quo
);
    import stdr_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [9:0]  rem_reg, rem_next;
    logic [47:0] sh_reg, sh_next;
    logic [48:0] negv;
    logic [9:0]  r_step;
    logic [47:0] s_step;
    logic [10:0] trial;

    always_comb
    begin
        negv = 49'd0 - {num[47], num} + DIV_BIAS;
        r_step = rem_reg;
        s_step = sh_reg;
        trial = '0;
        for (int k = 0; k < 4; k++)
        begin
            trial = {r_step, s_step[47]};
            if (trial >= DIV_CONST)
            begin
                r_step = 10'(trial - DIV_CONST);
                s_step = {s_step[46:0], 1'b1};
            end
            else
            begin
                r_step = trial[9:0];
                s_step = {s_step[46:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        sh_next = sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            neg_next = num[47];
            rem_next = '0;
            sh_next = num[47] ? negv[47:0] : num;
        end
        else if (busy_reg)
        begin
            rem_next = r_step;
            sh_next = s_step;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd11)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        sh_reg <= sh_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo = neg_reg ? signed'(48'd0 - sh_reg) : signed'(sh_reg);

endmodule

// File: src/stdr_cordic.sv
// iterative 16-step cordic giving sine and cosine of a binary angle
module stdr_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        heading,
    output logic               busy,
    output logic               done,
    output logic signed [17:0] sin16,
    output logic signed [17:0] cos16
);
    import stdr_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [3:0]         i_reg, i_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [31:0]        a0;
    logic [31:0]        a1;
    logic               fl;
    logic signed [33:0] dx, dy;
    logic signed [33:0] xf, yf, xr, yr;

    always_comb
    begin
        a0 = {heading, 16'd0};
        fl = (a0[31:30] == 2'b01) || (a0[31:30] == 2'b10);
        a1 = fl ? (a0 + 32'h8000_0000) : a0;
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next = i_reg;
        flip_next = flip_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next = '0;
            flip_next = fl;
            x_next = CORDIC_X0;
            y_next = '0;
            z_next = signed'({{2{a1[31]}}, a1});
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - signed'(atan_val(i_reg));
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + signed'(atan_val(i_reg));
            end
            i_next = i_reg + 4'd1;
            if (i_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb
    begin
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        xr = (xf + 34'sd8192) >>> 14;
        yr = (yf + 34'sd8192) >>> 14;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign cos16 = xr[17:0];
    assign sin16 = yr[17:0];

endmodule

// File: src/stdr_front.sv
// front end: accepts beats, checks the index, holds the count register and a short queue
module stdr_front #(
    parameter int MAX_TRACKS = stdr_pkg::MAX_TRACKS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  stdr_pkg::stdr_item_t   in_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [8:0]             cfg_data,
    output stdr_pkg::stdr_queue_t  q,
    input  stdr_pkg::stdr_back_ctl_t ctl
);
    import stdr_pkg::*;

    logic [8:0]  count_reg;
    stdr_item_t  fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    stdr_item_t  wr_item;

    assign cfg_ready = 1'b1;
    assign in_stall = (fill_reg == 2'd2) || ctl.clearing;
    assign push = in_valid && !in_stall;
    assign pop = ctl.pop && (fill_reg != 2'd0);

    always_comb
    begin
        wr_item = in_item;
        wr_item.ok = ({1'b0, in_item.idx} < count_reg)
                     && (32'(in_item.idx) < 32'(MAX_TRACKS));
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= wr_item;
    end

    assign q.valid = (fill_reg != 2'd0);
    assign q.item = fifo_reg[rd_ptr_reg];

endmodule

// File: src/stdr_back.sv
// back end: track memory, extrapolation sequencer and output register
`include "ship_track_dead_reckoning_macros.svh"
module stdr_back #(
    parameter int MAX_TRACKS = stdr_pkg::MAX_TRACKS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stdr_pkg::stdr_queue_t    q,
    output stdr_pkg::stdr_back_ctl_t ctl,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     ship_valid,
    output logic signed [31:0]       east_out,
    output logic signed [31:0]       north_out,
    output logic signed [15:0]       speed_out,
    output logic [15:0]              heading_out,
    output logic signed [15:0]       turn_rate_out
);
    import stdr_pkg::*;

    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    stdr_state_t        state_reg, state_next;
    logic [AW-1:0]      clr_reg;
    stdr_entry_t        mem [MAX_TRACKS];
    stdr_entry_t        rd_q;
    stdr_entry_t        ent_reg;
    stdr_entry_t        mem_wd;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [31:0]        t_reg;
    logic signed [31:0] d_reg;
    logic signed [50:0] prod_reg;
    logic signed [47:0] p_reg;
    logic signed [67:0] acc_reg;
    logic [15:0]        head_reg;
    logic signed [17:0] s_reg, c_reg;
    logic               axis_reg;
    logic               res_valid_reg;
    logic signed [31:0] res_east_reg, res_north_reg;
    logic               ov_reg;
    logic               sv_reg;
    logic signed [31:0] eo_reg, no_reg;
    logic signed [15:0] so_reg, to_reg;
    logic [15:0]        ho_reg;

    logic               pop;
    logic               out_load;
    logic               div_start, div_busy, div_done;
    logic signed [47:0] div_num, div_q;
    logic               cor_start, cor_busy, cor_done;
    logic signed [17:0] sin16, cos16;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [17:0] sc;
    logic signed [31:0] pos;
    logic signed [34:0] pos_sum;
    logic signed [31:0] pos_sat;

    stdr_div1000 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_q)
    );

    stdr_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .heading (head_reg),
        .busy    (cor_busy),
        .done    (cor_done),
        .sin16   (sin16),
        .cos16   (cos16)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(MAX_TRACKS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (q.valid && q.item.req == REQ_READ)
                    state_next = q.item.ok ? ST_DELTA : ST_OUT;
            end
            ST_DELTA: state_next = ST_MROT;
            ST_MROT:  state_next = ST_HGO;
            ST_HGO:   state_next = ST_HWAIT;
            ST_HWAIT: if (div_done) state_next = ST_CGO;
            ST_CGO:   state_next = ST_CWAIT;
            ST_CWAIT: if (cor_done) state_next = ST_MP;
            ST_MP:    state_next = ST_PSAVE;
            ST_PSAVE: state_next = ST_MEH;
            ST_MEH:   state_next = ST_MEL;
            ST_MEL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_EGO;
            ST_EGO:   state_next = ST_EWAIT;
            ST_EWAIT: if (div_done) state_next = axis_reg ? ST_OUT : ST_MEH;
            ST_OUT:   if (!ov_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop = 1'b0;
        mem_we = 1'b0;
        mem_wa = AW'(q.item.idx);
        mem_wd = '0;
        div_start = 1'b0;
        div_num = acc_reg[67:20];
        cor_start = 1'b0;
        out_load = 1'b0;
        sc = axis_reg ? c_reg : s_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
            end
            ST_IDLE:
            begin
                pop = q.valid;
                if (q.valid && q.item.req == REQ_STORE && q.item.ok)
                begin
                    mem_we = 1'b1;
                    mem_wd.east = q.item.east;
                    mem_wd.north = q.item.north;
                    mem_wd.speed = q.item.speed;
                    mem_wd.heading = q.item.heading;
                    mem_wd.turn = q.item.turn;
                    mem_wd.stamp = q.item.t;
                end
            end
            ST_MROT:
            begin
                mul_a = {d_reg[31], d_reg};
                mul_b = {{2{ent_reg.turn[15]}}, ent_reg.turn};
            end
            ST_HGO:
            begin
                div_start = 1'b1;
                div_num = prod_reg[47:0];
            end
            ST_CGO: cor_start = 1'b1;
            ST_MP:
            begin
                mul_a = {d_reg[31], d_reg};
                mul_b = {{2{ent_reg.speed[15]}}, ent_reg.speed};
            end
            ST_MEH:
            begin
                mul_a = {{9{p_reg[47]}}, p_reg[47:24]};
                mul_b = sc;
            end
            ST_MEL:
            begin
                mul_a = {9'd0, p_reg[23:0]};
                mul_b = sc;
            end
            ST_EGO:   div_start = 1'b1;
            ST_OUT:   out_load = !ov_reg || !out_stall;
            default:  pop = 1'b0;
        endcase
    end

    assign mul_p = 51'(mul_a) * 51'(mul_b);

    always_comb
    begin
        pos = axis_reg ? ent_reg.north : ent_reg.east;
        pos_sum = 35'(pos) + 35'(signed'(div_q[33:0]));
        if (pos_sum > 35'sd2147483647)
            pos_sat = 32'sh7fff_ffff;
        else if (pos_sum < -35'sd2147483648)
            pos_sat = 32'sh8000_0000;
        else
            pos_sat = pos_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_q <= mem[AW'(q.item.idx)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (out_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                t_reg <= q.item.t;
                res_valid_reg <= 1'b0;
                axis_reg <= 1'b0;
            end
            ST_DELTA:
            begin
                ent_reg <= rd_q;
                d_reg <= signed'(t_reg - rd_q.stamp);
                res_valid_reg <= 1'b1;
            end
            ST_MROT:  prod_reg <= mul_p;
            ST_HWAIT: if (div_done) head_reg <= ent_reg.heading + div_q[15:0];
            ST_CWAIT:
            begin
                if (cor_done)
                begin
                    s_reg <= sin16;
                    c_reg <= cos16;
                end
            end
            ST_MP:    prod_reg <= mul_p;
            ST_PSAVE: p_reg <= prod_reg[47:0];
            ST_MEH:   prod_reg <= mul_p;
            ST_MEL:
            begin
                acc_reg <= {prod_reg[43:0], 24'd0};
                prod_reg <= mul_p;
            end
            ST_ADD:   acc_reg <= acc_reg + 68'(prod_reg);
            ST_EWAIT:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                        res_north_reg <= pos_sat;
                    else
                        res_east_reg <= pos_sat;
                    axis_reg <= 1'b1;
                end
            end
            default:  t_reg <= t_reg;
        endcase
        if (out_load)
        begin
            sv_reg <= res_valid_reg;
            eo_reg <= res_valid_reg ? res_east_reg : '0;
            no_reg <= res_valid_reg ? res_north_reg : '0;
            so_reg <= res_valid_reg ? ent_reg.speed : '0;
            ho_reg <= res_valid_reg ? head_reg : '0;
            to_reg <= res_valid_reg ? ent_reg.turn : '0;
        end
    end

    assign ctl.pop = pop;
    assign ctl.clearing = (state_reg == ST_CLEAR);
    assign out_valid = ov_reg;
    assign ship_valid = sv_reg;
    assign east_out = eo_reg;
    assign north_out = no_reg;
    assign speed_out = so_reg;
    assign heading_out = ho_reg;
    assign turn_rate_out = to_reg;

    `STDR_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, state_reg == ST_CLEAR, !pop)
    `STDR_ASSERT_IMP(a_div_busy_wait, clk, rst_n, div_busy,
        state_reg == ST_HWAIT || state_reg == ST_EWAIT)
    `STDR_ASSERT_IMP(a_cordic_busy_wait, clk, rst_n, cor_busy, state_reg == ST_CWAIT)
    `STDR_ASSERT_NXT(a_read_dispatch, clk, rst_n,
        state_reg == ST_IDLE && q.valid && q.item.req == REQ_READ,
        state_reg == ST_DELTA || state_reg == ST_OUT)

endmodule

// File: src/ship_track_dead_reckoning.sv
// top level of the dead reckoning track table
//
// input channel: in_valid / in_stall, one beat per store or read request
// result channel: out_valid / out_stall, one beat per read request, none per store
// config channel: cfg_valid / cfg_ready, always ready, writes the ship count
// a store beat is written to memory from the idle state; a read beat runs through these steps:
//   memory read, turn-rate product, a divide by 1000 for the bearing,
//   a 16-step cordic, then per axis two partial products and another divide
// reads run one at a time through the shared divider and cordic
// a two-entry queue lets the front accept beats while a read is in progress
// an out-of-range read gives an all-zero beat with ship_valid low
// after reset the track memory is swept to zero, one entry a cycle,
//   all MAX_TRACKS entries, with in_stall high; the ship count resets to zero
// the result sits in an output register; while out_stall is high it holds,
//   the back end waits and the queue fills, then in_stall rises
module ship_track_dead_reckoning #(
    parameter int MAX_TRACKS = stdr_pkg::MAX_TRACKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         ship_index,
    input  logic [31:0]        time_ms,
    input  logic signed [31:0] east_pos,
    input  logic signed [31:0] north_pos,
    input  logic signed [15:0] speed_in,
    input  logic [15:0]        heading_in,
    input  logic signed [15:0] turn_rate_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ship_valid,
    output logic signed [31:0] east_out,
    output logic signed [31:0] north_out,
    output logic signed [15:0] speed_out,
    output logic [15:0]        heading_out,
    output logic signed [15:0] turn_rate_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import stdr_pkg::*;

    stdr_item_t     in_item;
    stdr_queue_t    q;
    stdr_back_ctl_t ctl;

    always_comb
    begin
        in_item.req = req_type;
        in_item.ok = 1'b0;
        in_item.idx = ship_index;
        in_item.t = time_ms;
        in_item.east = east_pos;
        in_item.north = north_pos;
        in_item.speed = speed_in;
        in_item.heading = heading_in;
        in_item.turn = turn_rate_in;
    end

    stdr_front #(.MAX_TRACKS(MAX_TRACKS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q         (q),
        .ctl       (ctl)
    );

    stdr_back #(.MAX_TRACKS(MAX_TRACKS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q             (q),
        .ctl           (ctl),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ship_valid    (ship_valid),
        .east_out      (east_out),
        .north_out     (north_out),
        .speed_out     (speed_out),
        .heading_out   (heading_out),
        .turn_rate_out (turn_rate_out)
    );

endmodule

// File: bench/ship_track_dead_reckoning_test.sv
// testbench for the dead reckoning track table: stores and reads checked against a predictor
`timescale 1ns / 1ps

class track_scoreboard;
    logic signed [31:0] east_tab [256];
    logic signed [31:0] north_tab [256];
    logic signed [15:0] speed_tab [256];
    logic [15:0]        heading_tab [256];
    logic signed [15:0] turn_tab [256];
    logic [31:0]        stamp_tab [256];
    logic [8:0]         ship_count;
    logic [112:0]       pending_tracks [$];
    int                 errors;
    int                 reads_seen;

    function new();
        for (int i = 0; i < 256; i++)
        begin
            east_tab[i] = 0; north_tab[i] = 0; speed_tab[i] = 0;
            heading_tab[i] = 0; turn_tab[i] = 0; stamp_tab[i] = 0;
        end
        ship_count = 0;
        errors = 0;
        reads_seen = 0;
    endfunction

    function void expect_track(logic [112:0] w);
        pending_tracks = {pending_tracks, w};
    endfunction

    function longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    function void cordic(logic [15:0] hdg, output longint s16, output longint c16);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, dx, dy;
        a = {hdg, 16'h0};
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip)
            a = a + 32'h8000_0000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - stdr_pkg::atan_val(i[3:0]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + stdr_pkg::atan_val(i[3:0]);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c16 = (x + 8192) >>> 14;
        s16 = (y + 8192) >>> 14;
    endfunction

    function void note_request(logic req, logic [7:0] idx, logic [31:0] t,
                               logic signed [31:0] e, logic signed [31:0] n,
                               logic signed [15:0] spd, logic [15:0] hdg,
                               logic signed [15:0] rot);
        bit          ok;
        longint      d, dang, s16, c16, p, de, dn, ne, nn;
        logic [15:0] h;
        ok = (idx < ship_count);
        if (req == stdr_pkg::REQ_STORE)
        begin
            if (ok)
            begin
                stamp_tab[idx] = t; east_tab[idx] = e; north_tab[idx] = n;
                speed_tab[idx] = spd; heading_tab[idx] = hdg; turn_tab[idx] = rot;
            end
            return;
        end
        if (!ok)
        begin
            expect_track('0);
            return;
        end
        d = longint'($signed(t - stamp_tab[idx]));
        dang = floor_div(d * longint'(turn_tab[idx]), 1000);
        h = heading_tab[idx] + dang[15:0];
        cordic(h, s16, c16);
        p = d * longint'(speed_tab[idx]);
        de = floor_div(p * s16, 1048576000);
        dn = floor_div(p * c16, 1048576000);
        ne = sat32(longint'(east_tab[idx]) + de);
        nn = sat32(longint'(north_tab[idx]) + dn);
        expect_track({1'b1, ne[31:0], nn[31:0], speed_tab[idx], h, turn_tab[idx]});
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_track(logic v, logic [31:0] e, logic [31:0] n, logic [15:0] spd,
                     logic [15:0] hdg, logic [15:0] rot);
        logic [112:0] w;
        reads_seen++;
        if (pending_tracks.size() == 0)
        begin
            report("result beat with nothing expected", 32'(v), 32'd0);
            return;
        end
        w = pending_tracks.pop_front();
        if (v !== w[112]) report("ship_valid", 32'(v), 32'(w[112]));
        if (e !== w[111:80]) report("east_out", e, w[111:80]);
        if (n !== w[79:48]) report("north_out", n, w[79:48]);
        if (spd !== w[47:32]) report("speed_out", 32'(spd), 32'(w[47:32]));
        if (hdg !== w[31:16]) report("heading_out", 32'(hdg), 32'(w[31:16]));
        if (rot !== w[15:0]) report("turn_rate_out", 32'(rot), 32'(w[15:0]));
    endtask
endclass

module ship_track_dead_reckoning_test;
    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               req_type = 0;
    logic [7:0]         ship_index = 0;
    logic [31:0]        time_ms = 0;
    logic signed [31:0] east_pos = 0;
    logic signed [31:0] north_pos = 0;
    logic signed [15:0] speed_in = 0;
    logic [15:0]        heading_in = 0;
    logic signed [15:0] turn_rate_in = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic               ship_valid;
    logic signed [31:0] east_out, north_out;
    logic signed [15:0] speed_out;
    logic [15:0]        heading_out;
    logic signed [15:0] turn_rate_out;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [8:0]         cfg_data = 0;

    track_scoreboard board;
    int  idle_cycles = 0;
    bit  long_hold;
    bit  sink_quiet;
    int  stores_sent, reads_sent;

    always #6 clk = ~clk;

    ship_track_dead_reckoning uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .ship_index(ship_index), .time_ms(time_ms),
        .east_pos(east_pos), .north_pos(north_pos), .speed_in(speed_in),
        .heading_in(heading_in), .turn_rate_in(turn_rate_in),
        .out_valid(out_valid), .out_stall(out_stall), .ship_valid(ship_valid),
        .east_out(east_out), .north_out(north_out), .speed_out(speed_out),
        .heading_out(heading_out), .turn_rate_out(turn_rate_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("ship_track_dead_reckoning test failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_track(ship_valid, east_out, north_out, speed_out,
                              heading_out, turn_rate_out);

    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                long_hold = 0;
                out_stall <= 0;
            end
            else if (sink_quiet)
                out_stall <= 0;
            else
            begin
                gap = $urandom_range(0, 8);
                if (gap != 0)
                begin
                    out_stall <= 1;
                    repeat (gap) @(posedge clk);
                end
                out_stall <= 0;
                do @(posedge clk); while (!out_valid && !long_hold);
            end
        end
    end

    task automatic send_beat(logic req, logic [7:0] idx, logic [31:0] t,
                             logic [31:0] e, logic [31:0] n, logic [15:0] spd,
                             logic [15:0] hdg, logic [15:0] rot, int gap);
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; req_type <= req; ship_index <= idx; time_ms <= t;
        east_pos <= e; north_pos <= n; speed_in <= spd; heading_in <= hdg;
        turn_rate_in <= rot;
        do @(posedge clk); while (in_stall);
        board.note_request(req, idx, t, e, n, spd, hdg, rot);
        if (req == stdr_pkg::REQ_STORE) stores_sent++; else reads_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending_tracks.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_count(logic [8:0] cnt);
        drain();
        cfg_valid <= 1;
        cfg_data <= cnt;
        do @(posedge clk); while (!cfg_ready);
        board.ship_count = cnt;
        cfg_valid <= 0;
    endtask

    task automatic random_beat(int span, bit quiet);
        logic [7:0]  idx;
        logic [31:0] t;
        idx = 8'($urandom_range(0, span));
        if ($urandom_range(0, 3) == 0)
            t = $urandom;
        else
            t = board.stamp_tab[idx] + $urandom_range(0, 200000) - 100000;
        send_beat(1'($urandom_range(0, 1)), idx, t, $urandom, $urandom, 16'($urandom),
                  16'($urandom), 16'($urandom), quiet ? 0 : int'($urandom_range(0, 8)));
    endtask

    initial
    begin
        board = new();
        long_hold = 0;
        sink_quiet = 0;
        stores_sent = 0;
        reads_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_beat(stdr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(stdr_pkg::REQ_STORE, 0, 5, 1, 1, 1, 1, 1, 0);
        set_count(9'd256);
        send_beat(stdr_pkg::REQ_READ, 255, 1000, 0, 0, 0, 0, 0, 0);
        send_beat(stdr_pkg::REQ_STORE, 255, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  16'h7FFF, 16'hFFFF, 16'h7FFF, 0);
        send_beat(stdr_pkg::REQ_READ, 255, 32'h7FFF_FFFE, 0, 0, 0, 0, 0, 0);
        send_beat(stdr_pkg::REQ_READ, 255, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        send_beat(stdr_pkg::REQ_STORE, 1, 1000, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'h8000, 16'h4000, 16'h8000, 0);
        send_beat(stdr_pkg::REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        send_beat(stdr_pkg::REQ_READ, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        for (int h = 0; h < 8; h++)
        begin
            send_beat(stdr_pkg::REQ_STORE, 2, 0, 0, 0, 16'h0100, 16'(h) * 16'h2000, 0, 0);
            send_beat(stdr_pkg::REQ_READ, 2, 10000, 0, 0, 0, 0, 0, 0);
        end
        set_count(9'd300);
        send_beat(stdr_pkg::REQ_READ, 255, 0, 0, 0, 0, 0, 0, 0);
        set_count(9'd3);
        send_beat(stdr_pkg::REQ_STORE, 3, 0, 7, 7, 7, 7, 7, 0);
        send_beat(stdr_pkg::REQ_READ, 3, 0, 0, 0, 0, 0, 0, 0);
        send_beat(stdr_pkg::REQ_READ, 2, 20000, 0, 0, 0, 0, 0, 0);

        set_count(9'd16);
        for (int i = 0; i < 150; i++)
            random_beat(20, 0);
        long_hold = 1;
        for (int i = 0; i < 12; i++)
            random_beat(20, 1);
        set_count(9'd256);
        for (int i = 0; i < 150; i++)
            random_beat(255, 0);
        drain();
        sink_quiet = 1;
        for (int i = 0; i < 30; i++)
            random_beat(255, 1);
        sink_quiet = 0;
        set_count(9'd1);
        for (int i = 0; i < 40; i++)
            random_beat(3, 0);
        set_count(9'd200);
        for (int i = 0; i < 70; i++)
            random_beat(255, 0);
        drain();

        $display("%0d stores and %0d reads sent, %0d result beats checked", stores_sent,
                 reads_sent, board.reads_seen);
        $display("ship counts 0, 1, 3, 16, 200, 256 and 300 were used");
        if (board.errors == 0 && board.pending_tracks.size() == 0)
            $display("ship_track_dead_reckoning test passed");
        else
            $display("ship_track_dead_reckoning test failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/stdr_pkg.sv
src/stdr_div1000.sv
src/stdr_cordic.sv
src/stdr_front.sv
src/stdr_back.sv
src/ship_track_dead_reckoning.sv
bench/ship_track_dead_reckoning_test.sv
